// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted (active low reset).
`define GPFP_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that is also checked during reset.
`define GPFP_ASSERT_RST(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== design/gpfp_pkg.sv =====
// ----------------------------------------------------------------------------
// gpfp_pkg
// Types, constants and the sort compare of the grouped Pareto-front pruner.
// ----------------------------------------------------------------------------
package gpfp_pkg;

    localparam int GROUP_W = 10;
    localparam int SITE_W  = 31;
    localparam int SCORE_W = 32;
    localparam int TAG_W   = 16;

    localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

    // One candidate entry as held in a cell
    typedef struct packed {
        logic [GROUP_W-1:0] group_id;
        logic [SITE_W-1:0]  site;
        logic [SCORE_W-1:0] score;
        logic [TAG_W-1:0]   tag;
    } t_entry;

    // What a cell shows its neighbors
    typedef struct packed {
        logic   valid;
        logic   ins;    // new entry lands at or before this cell
        t_entry entry;
    } t_link;

    // Chain control broadcast to every cell
    typedef struct packed {
        logic load;     // insert the new entry
        logic drain;    // shift everything one cell toward the head
    } t_chain_ctl;

    // One result beat
    typedef struct packed {
        t_entry entry;
        logic   last;
        logic   ovf;
    } t_result;

    typedef enum logic [0:0] {
        PH_LOAD,
        PH_DRAIN
    } t_phase;

    // Group ascending, site descending, score ascending; equal is not before
    function automatic logic sorts_before(t_entry a, t_entry b);
        logic res;
        if (a.group_id != b.group_id) begin
            res = (a.group_id < b.group_id);
        end else if (a.site != b.site) begin
            res = (a.site > b.site);
        end else begin
            res = (a.score < b.score);
        end
        return res;
    endfunction

endpackage

// ===== design/gpfp_if.sv =====
// ----------------------------------------------------------------------------
// gpfp_in_if / gpfp_out_if
// Valid/ready channels for candidate beats and result beats.
// ----------------------------------------------------------------------------
interface gpfp_in_if;
    logic        valid;
    logic        ready;
    logic [9:0]  group_id;
    logic [30:0] site;
    logic [31:0] score;
    logic [15:0] entry_tag;
    logic        last;

    modport source (output valid, group_id, site, score, entry_tag, last, input ready);
    modport sink   (input valid, group_id, site, score, entry_tag, last, output ready);
endinterface

interface gpfp_out_if;
    logic        valid;
    logic        ready;
    logic [9:0]  out_group_id;
    logic [30:0] out_site;
    logic [31:0] out_score;
    logic [15:0] out_tag;
    logic        out_last;
    logic        overflow;

    modport source (output valid, out_group_id, out_site, out_score, out_tag, out_last,
                    overflow, input ready);
    modport sink   (input valid, out_group_id, out_site, out_score, out_tag, out_last,
                    overflow, output ready);
endinterface

// ===== design/gpfp_cell.sv =====
// ----------------------------------------------------------------------------
// gpfp_cell
// One slot of the sorted insertion chain: holds an entry, takes the new
// entry or its left neighbor on insert, takes its right neighbor on drain.
// ----------------------------------------------------------------------------
module gpfp_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  gpfp_pkg::t_chain_ctl   i_ctl,
    input  gpfp_pkg::t_entry       i_new,
    input  gpfp_pkg::t_link        i_left,
    input  gpfp_pkg::t_link        i_right,
    output gpfp_pkg::t_link        o_link
);
    import gpfp_pkg::*;

    logic   r_valid, n_valid;
    t_entry r_entry, n_entry;
    logic   w_ins;

    // empty cells and cells that sort after the new entry make room
    assign w_ins = !r_valid || sorts_before(i_new, r_entry);

    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        if (i_ctl.load && w_ins) begin
            if (i_left.ins) begin
                n_valid = i_left.valid;
                n_entry = i_left.entry;
            end else begin
                n_valid = 1'b1;
                n_entry = i_new;
            end
        end else if (i_ctl.drain) begin
            n_valid = i_right.valid;
            n_entry = i_right.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_link = '{valid: r_valid, ins: w_ins, entry: r_entry};

endmodule

// ===== design/gpfp_prune.sv =====
// ----------------------------------------------------------------------------
// gpfp_prune
// Pops the chain head, keeps the per-group front, holds one survivor back
// so the final one can be tagged, and drives the result register.
// ----------------------------------------------------------------------------
module gpfp_prune (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_active,
    input  logic                i_ovf,
    input  gpfp_pkg::t_link     i_head,
    output logic                o_pop,
    output logic                o_done,
    gpfp_out_if.source          o_out
);
    import gpfp_pkg::*;

    logic [SCORE_W-1:0] r_min, n_min;
    logic [GROUP_W-1:0] r_prev_group, n_prev_group;
    logic               r_have_prev, n_have_prev;
    t_entry             r_pend, n_pend;
    logic               r_pend_v, n_pend_v;
    t_result            r_out, n_out;
    logic               r_out_v, n_out_v;
    logic               w_keep;
    logic               w_out_free;

    assign w_keep = !r_have_prev || (i_head.entry.group_id != r_prev_group) ||
                    (i_head.entry.score < r_min);
    assign w_out_free = !r_out_v || o_out.ready;

    always_comb begin
        o_pop        = 1'b0;
        o_done       = 1'b0;
        n_min        = r_min;
        n_prev_group = r_prev_group;
        n_have_prev  = r_have_prev;
        n_pend       = r_pend;
        n_pend_v     = r_pend_v;
        n_out        = r_out;
        n_out_v      = r_out_v;

        // result beat taken
        if (r_out_v && o_out.ready) begin
            n_out_v = 1'b0;
        end

        if (i_active) begin
            if (i_head.valid) begin
                if (!w_keep) begin
                    o_pop = 1'b1;
                end else if (!r_pend_v || w_out_free) begin
                    // new survivor; the held one is known not to be last
                    o_pop        = 1'b1;
                    n_min        = i_head.entry.score;
                    n_prev_group = i_head.entry.group_id;
                    n_have_prev  = 1'b1;
                    n_pend       = i_head.entry;
                    n_pend_v     = 1'b1;
                    if (r_pend_v) begin
                        n_out   = '{entry: r_pend, last: 1'b0, ovf: i_ovf};
                        n_out_v = 1'b1;
                    end
                end
            end else if (!r_pend_v) begin
                o_done = 1'b1;
            end else if (w_out_free) begin
                // chain empty: held survivor closes the set
                n_out    = '{entry: r_pend, last: 1'b1, ovf: i_ovf};
                n_out_v  = 1'b1;
                n_pend_v = 1'b0;
                o_done   = 1'b1;
            end
            if (o_done) begin
                n_have_prev = 1'b0;
                n_min       = SCORE_MAX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min       <= SCORE_MAX;
            r_have_prev <= 1'b0;
            r_pend_v    <= 1'b0;
            r_out_v     <= 1'b0;
        end else begin
            r_min       <= n_min;
            r_have_prev <= n_have_prev;
            r_pend_v    <= n_pend_v;
            r_out_v     <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev_group <= n_prev_group;
        r_pend       <= n_pend;
        r_out        <= n_out;
    end

    assign o_out.valid        = r_out_v;
    assign o_out.out_group_id = r_out.entry.group_id;
    assign o_out.out_site     = r_out.entry.site;
    assign o_out.out_score    = r_out.entry.score;
    assign o_out.out_tag      = r_out.entry.tag;
    assign o_out.out_last     = r_out.last;
    assign o_out.overflow     = r_out.ovf;

endmodule

// ===== design/grouped_pareto_front_prune_core.sv =====
// ----------------------------------------------------------------------------
// grouped_pareto_front_prune_core
// Per-group two-dimensional Pareto front of a set of candidate entries.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries candidate beats (group_id, site, score, entry_tag, last).
//   While loading, i_in.ready is high and one beat is taken every cycle;
//   each beat is inserted into a sorted chain of MAX_ENTRIES cells as it
//   is taken (group up, site down, score up, ties in arrival order). A beat
//   that finds the chain full is dropped and flags overflow for the set.
//   The beat with last set starts the drain: i_in.ready drops, the chain
//   shifts one cell per cycle into the pruner, and survivors leave on o_out
//   in chain order. The first result of a set leaves only once a second
//   survivor is found or the chain is empty, since one survivor is held
//   back to mark out_last. o_out stalls hold the drain at the next
//   survivor; nothing is lost. The final result of a set may still wait
//   in the output register while the next set loads.
//   Reset (synchronous, active low) empties the chain and the outputs.
// ----------------------------------------------------------------------------
module grouped_pareto_front_prune_core #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gpfp_in_if.sink     i_in,
    gpfp_out_if.source  o_out
);
    import gpfp_pkg::*;

    t_phase     r_phase, n_phase;
    logic       r_dropped, n_dropped;
    t_chain_ctl w_ctl;
    t_entry     w_new;
    t_link      w_link  [MAX_ENTRIES];
    t_link      w_left  [MAX_ENTRIES];
    t_link      w_right [MAX_ENTRIES];
    logic       w_accept;
    logic       w_full;
    logic       w_pop;
    logic       w_done;

    assign i_in.ready = (r_phase == PH_LOAD);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_full     = w_link[MAX_ENTRIES-1].valid;

    assign w_new = '{group_id: i_in.group_id, site: i_in.site,
                     score: i_in.score, tag: i_in.entry_tag};

    assign w_ctl.load  = w_accept && !w_full;
    assign w_ctl.drain = w_pop;

    // insertion chain
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_left[g] = '{valid: 1'b1, ins: 1'b0, entry: w_new};
        end else begin : g_mid
            assign w_left[g] = w_link[g-1];
        end
        if (g == MAX_ENTRIES - 1) begin : g_tail
            assign w_right[g] = '{valid: 1'b0, ins: 1'b1, entry: w_new};
        end else begin : g_body
            assign w_right[g] = w_link[g+1];
        end

        gpfp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_new   (w_new),
            .i_left  (w_left[g]),
            .i_right (w_right[g]),
            .o_link  (w_link[g])
        );
    end

    gpfp_prune u_prune (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_active (r_phase == PH_DRAIN),
        .i_ovf    (r_dropped),
        .i_head   (w_link[0]),
        .o_pop    (w_pop),
        .o_done   (w_done),
        .o_out    (o_out)
    );

    // load / drain sequencing
    always_comb begin
        n_phase   = r_phase;
        n_dropped = r_dropped;
        unique case (r_phase)
            PH_LOAD: begin
                if (w_accept) begin
                    if (w_full) begin
                        n_dropped = 1'b1;
                    end
                    if (i_in.last) begin
                        n_phase = PH_DRAIN;
                    end
                end
            end
            PH_DRAIN: begin
                if (w_done) begin
                    n_phase   = PH_LOAD;
                    n_dropped = 1'b0;
                end
            end
            default: begin
                n_phase = PH_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_LOAD;
            r_dropped <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_dropped <= n_dropped;
        end
    end

endmodule

// ===== design/gpfp_checker.sv =====
// ----------------------------------------------------------------------------
// gpfp_checker
// Port-level checks of the pruner core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gpfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_last,
    input logic        o_valid,
    input logic        o_ready,
    input logic        o_last,
    input logic        o_overflow,
    input logic [31:0] o_score
);

    // result register is empty right after reset
    `GPFP_ASSERT_RST(a_rst_empty, i_clk, !i_rst_n |=> !o_valid, "result valid after reset")

    // the last beat of a set closes the input for the drain
    `GPFP_ASSERT(a_last_closes, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_last |=> !i_in_ready, "input open after last beat")

    // overflow is one value across a set
    `GPFP_ASSERT(a_ovf_set, i_clk, i_rst_n, o_valid && o_ready && !o_last |=> !o_valid || (o_overflow == $past(o_overflow)), "overflow changed within a set")

    // a stalled result holds
    `GPFP_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !o_ready |=> o_valid && $stable(o_score) && $stable(o_last), "stalled result changed")

endmodule

bind grouped_pareto_front_prune_core gpfp_checker u_gpfp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in.valid),
    .i_in_ready (i_in.ready),
    .i_in_last  (i_in.last),
    .o_valid    (o_out.valid),
    .o_ready    (o_out.ready),
    .o_last     (o_out.out_last),
    .o_overflow (o_out.overflow),
    .o_score    (o_out.out_score)
);
